/* sv/i2cgx_pkg.sv */
package i2cgx_pkg;

  localparam int LED_CAPACITY = 128;
  localparam int LED_BYTES    = LED_CAPACITY * 3;
  localparam int LED_AW       = $clog2(LED_BYTES);

  typedef logic [1:0] op_t;
  typedef logic [1:0] dev_t;

  // bus event codes
  localparam op_t OP_ADDR  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_READ  = 2'd2;
  localparam op_t OP_STOP  = 2'd3;

  // selected device codes
  localparam dev_t DEV_NONE     = 2'd0;
  localparam dev_t DEV_EXPANDER = 2'd1;
  localparam dev_t DEV_LEDS     = 2'd2;

  localparam logic [7:0]  ADDR_MASK     = 8'hf9;
  localparam logic [6:0]  EXP_ADDR      = 7'h20;
  localparam logic [6:0]  LED_ADDR      = 7'h30;
  localparam logic [7:0]  LED_COUNT_REG = 8'hff;
  localparam logic [15:0] PTR_PENDING   = 16'hffff;
  localparam logic [7:0]  REG_RESET     = 8'hff;

endpackage

/* sv/i2c_gpio_expander_led_regs.sv */
// Byte-level I2C target register file. Each transfer on the in_ channel is one
// bus event (address byte, written byte, read request, stop); each produces
// exactly one transfer on the out_ channel carrying the read byte, the
// current pin drive and pull-up maps, and the LED launch flag and count.
// Device 0x20-0x23 is a 16-bit GPIO expander; 0x30-0x33 is an LED byte store
// of 384 bytes held in a single-port synchronous RAM. The RAM is read or
// written as an event is accepted into the middle stage, and the result
// register loads from that stage once the output side can take it; in_stall
// holds off a new event until the middle stage empties. The LED RAM is
// zeroed after reset by a clearing pass over all 384 bytes, in_stall high.
module i2c_gpio_expander_led_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cgx_pkg::op_t        in_operation,
  input  logic [7:0]            in_bus_byte,
  input  logic [7:0]            in_port_a_pins,
  input  logic [7:0]            in_port_b_pins,
  input  logic [7:0]            in_port_c_pins,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_read_data,
  output logic [7:0]            out_port_a_level,
  output logic [7:0]            out_port_b_level,
  output logic [7:0]            out_port_c_level,
  output logic [7:0]            out_port_a_input_mode,
  output logic [7:0]            out_port_b_input_mode,
  output logic [7:0]            out_port_c_input_mode,
  output logic                  out_led_start,
  output logic [7:0]            out_led_count
);
  import i2cgx_pkg::*;

  // architectural state
  dev_t        dev_r, dev_nxt;
  logic [7:0]  ptr_r, ptr_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  outreg_r [2];
  logic [7:0]  dirreg_r [2];

  // LED byte RAM
  logic [7:0]        led_mem [LED_BYTES];
  logic [7:0]        mem_q_r;
  logic              mem_we, mem_re;
  logic [LED_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  // clearing pass
  logic              clr_busy_r;
  logic [LED_AW-1:0] clr_addr_r;

  // middle stage (waits for RAM read data)
  logic       s1_r;
  logic       s1_mem_sel_r, s1_mem_sel_nxt;
  logic [7:0] s1_rd_r, s1_rd_nxt;
  logic       s1_start_r, s1_start_nxt;
  logic [7:0] s1_count_r, s1_count_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_rd_r;
  logic       out_start_r;
  logic [7:0] out_count_r;
  logic [7:1] out_lvl0_r, out_lvl1_r;
  logic [7:1] out_mode0_r, out_mode1_r;

  logic        acc, s1_adv;
  logic [9:0]  ptr3;
  logic [16:0] led_idx;
  logic [16:0] reg_pos;
  logic        led_in_range;
  logic        ptr_is_out, ptr_is_dir, pos_is_out, pos_is_dir;
  logic [6:0]  addr7;
  logic [7:0]  in_word;
  logic        in_bit0;
  logic        led_wr_en, out_wr_en, dir_wr_en;

  assign acc      = in_valid && !in_stall;
  assign in_stall = clr_busy_r || s1_r;
  assign s1_adv   = s1_r && (!out_valid_r || !out_stall);

  assign ptr3         = {1'b0, ptr_r, 1'b0} + {2'b00, ptr_r};
  assign led_idx      = {7'd0, ptr3} + {1'b0, cnt_r};
  assign reg_pos      = {9'd0, ptr_r} + {1'b0, cnt_r};
  assign led_in_range = led_idx < 17'(LED_BYTES);
  assign ptr_is_out   = (ptr_r == 8'd2) || (ptr_r == 8'd3);
  assign ptr_is_dir   = (ptr_r == 8'd6) || (ptr_r == 8'd7);
  assign pos_is_out   = (reg_pos == 17'd2) || (reg_pos == 17'd3);
  assign pos_is_dir   = (reg_pos == 17'd6) || (reg_pos == 17'd7);
  assign addr7        = 7'((in_bus_byte & ADDR_MASK) >> 1);

  // unconnected input bit 0 reads the direction bit when set, else output bit
  always_comb begin
    in_bit0 = dirreg_r[reg_pos[0]][0] | outreg_r[reg_pos[0]][0];
    if (reg_pos[0] == 1'b0) begin
      in_word = {in_port_a_pins[7:1], in_bit0};
    end else begin
      in_word = {in_port_b_pins[7:3], in_port_c_pins[4:3], in_bit0};
    end
  end

  always_comb begin
    dev_nxt        = dev_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    s1_mem_sel_nxt = 1'b0;
    s1_rd_nxt      = '0;
    s1_start_nxt   = 1'b0;
    s1_count_nxt   = '0;
    led_wr_en      = 1'b0;
    out_wr_en      = 1'b0;
    dir_wr_en      = 1'b0;
    case (in_operation)
      OP_ADDR: begin
        if (addr7 == EXP_ADDR) begin
          dev_nxt = DEV_EXPANDER;
        end else if (addr7 == LED_ADDR) begin
          dev_nxt = DEV_LEDS;
        end else begin
          dev_nxt = DEV_NONE;
        end
        cnt_nxt = in_bus_byte[0] ? 16'd0 : PTR_PENDING;
      end
      OP_WRITE: begin
        if (cnt_r == PTR_PENDING) begin
          ptr_nxt = in_bus_byte;
        end else if (dev_r == DEV_LEDS) begin
          if (ptr_r == LED_COUNT_REG) begin
            pend_nxt = in_bus_byte;
          end else if (led_in_range) begin
            led_wr_en = 1'b1;
          end
        end else if (dev_r == DEV_EXPANDER) begin
          if (ptr_is_out && pos_is_out) begin
            out_wr_en = 1'b1;
          end else if (ptr_is_dir && pos_is_dir) begin
            dir_wr_en = 1'b1;
          end
        end
        cnt_nxt = cnt_r + 16'd1;
      end
      OP_READ: begin
        if (dev_r == DEV_LEDS) begin
          if (ptr_r == LED_COUNT_REG) begin
            s1_rd_nxt = 8'(LED_CAPACITY);
          end else if (led_in_range) begin
            s1_mem_sel_nxt = 1'b1;
          end
        end else if (dev_r == DEV_EXPANDER) begin
          if (ptr_r <= 8'd1 && reg_pos <= 17'd1) begin
            s1_rd_nxt = in_word;
          end else if (ptr_is_out && pos_is_out) begin
            s1_rd_nxt = outreg_r[reg_pos[0]];
          end else if (ptr_is_dir && pos_is_dir) begin
            s1_rd_nxt = dirreg_r[reg_pos[0]];
          end
        end
        cnt_nxt = cnt_r + 16'd1;
      end
      default: begin
        if (dev_r == DEV_LEDS && ptr_r == LED_COUNT_REG && pend_r != 8'd0) begin
          s1_start_nxt = 1'b1;
          s1_count_nxt = pend_r;
          pend_nxt     = 8'd0;
        end
        ptr_nxt = 8'd0;
      end
    endcase
  end

  // RAM port: clearing pass owns it until done
  always_comb begin
    mem_we    = clr_busy_r || (acc && led_wr_en);
    mem_re    = acc && s1_mem_sel_nxt;
    mem_addr  = clr_busy_r ? clr_addr_r : led_idx[LED_AW-1:0];
    mem_wdata = clr_busy_r ? 8'd0 : in_bus_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      led_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= led_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + LED_AW'(1);
      if (clr_addr_r == LED_AW'(LED_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r       <= DEV_NONE;
      ptr_r       <= 8'd0;
      cnt_r       <= 16'd0;
      pend_r      <= 8'd0;
      outreg_r[0] <= REG_RESET;
      outreg_r[1] <= REG_RESET;
      dirreg_r[0] <= REG_RESET;
      dirreg_r[1] <= REG_RESET;
    end else if (acc) begin
      dev_r  <= dev_nxt;
      ptr_r  <= ptr_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      if (out_wr_en) begin
        outreg_r[reg_pos[0]] <= in_bus_byte;
      end
      if (dir_wr_en) begin
        dirreg_r[reg_pos[0]] <= in_bus_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
    end else if (acc) begin
      s1_r <= 1'b1;
    end else if (s1_adv) begin
      s1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_mem_sel_r <= s1_mem_sel_nxt;
      s1_rd_r      <= s1_rd_nxt;
      s1_start_r   <= s1_start_nxt;
      s1_count_r   <= s1_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // pin maps are captured with the result so they hold while it waits
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rd_r    <= s1_mem_sel_r ? mem_q_r : s1_rd_r;
      out_start_r <= s1_start_r;
      out_count_r <= s1_count_r;
      out_lvl0_r  <= outreg_r[0][7:1];
      out_lvl1_r  <= outreg_r[1][7:1];
      out_mode0_r <= dirreg_r[0][7:1];
      out_mode1_r <= dirreg_r[1][7:1];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = out_rd_r;
  assign out_led_start         = out_start_r;
  assign out_led_count         = out_count_r;
  assign out_port_a_level      = {out_lvl0_r, 1'b0};
  assign out_port_b_level      = {out_lvl1_r[7:3], 3'b000};
  assign out_port_c_level      = {3'b000, out_lvl1_r[2:1], 3'b000};
  assign out_port_a_input_mode = {out_mode0_r, 1'b0};
  assign out_port_b_input_mode = {out_mode1_r[7:3], 3'b000};
  assign out_port_c_input_mode = {3'b000, out_mode1_r[2:1], 3'b000};

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("event accepted while previous still in flight");

  a_no_out_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !out_valid_r)
    else $error("result emitted during RAM clearing pass");

  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_led_start) |-> (out_led_count != 8'd0 && out_read_data == 8'd0))
    else $error("LED launch with zero count or read data");

  a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && clr_busy_r) && !(mem_re && mem_we))
    else $error("RAM read collides with write or clearing pass");
`endif

endmodule

/* verif/i2c_gpio_expander_led_regs_test.sv */
module i2c_gpio_expander_led_regs_test;
  import i2cgx_pkg::*;

  localparam logic [7:0] EXP_WR      = {EXP_ADDR, 1'b0};
  localparam logic [7:0] LED_WR      = {LED_ADDR, 1'b0};
  localparam logic [7:0] NO_DEV_WR   = 8'h00;
  localparam logic [7:0] RD_BIT      = 8'h01;
  localparam logic [7:0] SUB_BITS    = 8'h06;
  localparam logic [7:0] REG_INPUT0  = 8'd0;
  localparam logic [7:0] REG_OUTPUT0 = 8'd2;
  localparam logic [7:0] REG_DIR0    = 8'd6;
  localparam logic [23:0] PINS_HIGH  = 24'hffffff;
  localparam logic [23:0] PINS_LOW   = 24'h000000;
  localparam int unsigned RANDOM_EVENTS = 1600;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] a_level;
    logic [7:0] b_level;
    logic [7:0] c_level;
    logic [7:0] a_mode;
    logic [7:0] b_mode;
    logic [7:0] c_mode;
    logic       led_start;
    logic [7:0] led_count;
  } bus_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  op_t        in_operation = OP_ADDR;
  logic [7:0] in_bus_byte = 8'h00;
  logic [7:0] in_port_a_pins = 8'h00;
  logic [7:0] in_port_b_pins = 8'h00;
  logic [7:0] in_port_c_pins = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic [7:0] out_port_a_level;
  logic [7:0] out_port_b_level;
  logic [7:0] out_port_c_level;
  logic [7:0] out_port_a_input_mode;
  logic [7:0] out_port_b_input_mode;
  logic [7:0] out_port_c_input_mode;
  logic       out_led_start;
  logic [7:0] out_led_count;

  // expander / LED store state as seen from the bus
  dev_t        sel_dev = DEV_NONE;
  logic [7:0]  reg_ptr = 8'h00;
  logic [15:0] byte_cnt = 16'h0000;
  logic [7:0]  out_regs [2] = '{REG_RESET, REG_RESET};
  logic [7:0]  dir_regs [2] = '{REG_RESET, REG_RESET};
  logic [7:0]  led_mem [LED_BYTES] = '{default: 8'h00};
  logic [7:0]  pend_cnt = 8'h00;

  bus_reply_t  pending_replies [$];
  bus_reply_t  head;
  int unsigned events_sent = 0;
  int unsigned mismatches = 0;
  bit          steady = 1'b0;

  i2c_gpio_expander_led_regs dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[i2c_gpio_expander_led_regs] ERROR");
    $finish;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 36);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // access stays inside a register pair and started on one of its two registers
  function automatic bit in_pair(logic [7:0] base, int unsigned pos);
    return (reg_ptr == base || reg_ptr == base + 8'd1) && (pos == base || pos == base + 1);
  endfunction

  function automatic bus_reply_t apply_bus_event(op_t op, logic [7:0] data,
                                                 logic [7:0] pa, logic [7:0] pb,
                                                 logic [7:0] pc);
    bus_reply_t  r;
    int unsigned led_idx;
    int unsigned reg_pos;
    int unsigned half;
    logic [6:0]  dev_addr;
    logic        bit0;
    r = '0;
    led_idx = reg_ptr * 3 + byte_cnt;
    reg_pos = reg_ptr + byte_cnt;
    case (op)
      OP_ADDR: begin
        dev_addr = 7'((data & ADDR_MASK) >> 1);
        sel_dev = dev_addr == EXP_ADDR ? DEV_EXPANDER :
                  dev_addr == LED_ADDR ? DEV_LEDS : DEV_NONE;
        byte_cnt = data[0] ? 16'h0000 : PTR_PENDING;
      end
      OP_WRITE: begin
        if (byte_cnt == PTR_PENDING) begin
          reg_ptr = data;
        end else if (sel_dev == DEV_LEDS) begin
          if (reg_ptr == LED_COUNT_REG) pend_cnt = data;
          else if (led_idx < LED_BYTES) led_mem[led_idx] = data;
        end else if (sel_dev == DEV_EXPANDER) begin
          if (in_pair(REG_OUTPUT0, reg_pos)) out_regs[reg_pos - REG_OUTPUT0] = data;
          else if (in_pair(REG_DIR0, reg_pos)) dir_regs[reg_pos - REG_DIR0] = data;
        end
        byte_cnt = byte_cnt + 16'd1;
      end
      OP_READ: begin
        if (sel_dev == DEV_LEDS) begin
          if (reg_ptr == LED_COUNT_REG) r.read_data = 8'(LED_CAPACITY);
          else if (led_idx < LED_BYTES) r.read_data = led_mem[led_idx];
        end else if (sel_dev == DEV_EXPANDER) begin
          if (in_pair(REG_INPUT0, reg_pos)) begin
            half = reg_pos - REG_INPUT0;
            // unconnected bit 0 reads the pull-up when input, else the driven level
            bit0 = dir_regs[half][0] | out_regs[half][0];
            r.read_data = half == 0 ? {pa[7:1], bit0} : {pb[7:3], pc[4:3], bit0};
          end else if (in_pair(REG_OUTPUT0, reg_pos)) begin
            r.read_data = out_regs[reg_pos - REG_OUTPUT0];
          end else if (in_pair(REG_DIR0, reg_pos)) begin
            r.read_data = dir_regs[reg_pos - REG_DIR0];
          end
        end
        byte_cnt = byte_cnt + 16'd1;
      end
      default: begin
        if (sel_dev == DEV_LEDS && reg_ptr == LED_COUNT_REG && pend_cnt != 8'h00) begin
          r.led_start = 1'b1;
          r.led_count = pend_cnt;
          pend_cnt = 8'h00;
        end
        reg_ptr = 8'h00;
      end
    endcase
    r.a_level = {out_regs[0][7:1], 1'b0};
    r.b_level = {out_regs[1][7:3], 3'b000};
    r.c_level = {3'b000, out_regs[1][2:1], 3'b000};
    r.a_mode  = {dir_regs[0][7:1], 1'b0};
    r.b_mode  = {dir_regs[1][7:3], 3'b000};
    r.c_mode  = {3'b000, dir_regs[1][2:1], 3'b000};
    return r;
  endfunction

  // pins packed as {port A, port B, port C}
  task automatic send_event(op_t op, logic [7:0] data, logic [23:0] pins);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_bus_byte <= data;
    {in_port_a_pins, in_port_b_pins, in_port_c_pins} <= pins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_replies.push_back(apply_bus_event(op, data, pins[23:16], pins[15:8], pins[7:0]));
    events_sent++;
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t %s expected %02h actual %02h", $time, field, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual read_data %02h",
                 $time, out_read_data);
        mismatches++;
      end else begin
        head = pending_replies.pop_front();
        check_field("read_data", head.read_data, out_read_data);
        check_field("port_a_level", head.a_level, out_port_a_level);
        check_field("port_b_level", head.b_level, out_port_b_level);
        check_field("port_c_level", head.c_level, out_port_c_level);
        check_field("port_a_input_mode", head.a_mode, out_port_a_input_mode);
        check_field("port_b_input_mode", head.b_mode, out_port_b_input_mode);
        check_field("port_c_input_mode", head.c_mode, out_port_c_input_mode);
        check_field("led_start", head.led_start, out_led_start);
        check_field("led_count", head.led_count, out_led_count);
      end
    end
    out_stall <= take_gap();
  end

  // output pair write with a pointer byte, then readback past the pair end
  task automatic test_expander_outputs();
    send_event(OP_ADDR, EXP_WR, 24'($urandom));
    send_event(OP_WRITE, REG_OUTPUT0, 24'($urandom));
    send_event(OP_WRITE, 8'h00, 24'($urandom));
    send_event(OP_WRITE, 8'ha5, 24'($urandom));
    send_event(OP_ADDR, EXP_WR | RD_BIT, 24'($urandom));
    send_event(OP_READ, 8'h00, 24'($urandom));
    send_event(OP_READ, 8'hff, 24'($urandom));
    send_event(OP_READ, 8'h00, 24'($urandom));
    send_event(OP_STOP, 8'h00, 24'($urandom));
  endtask

  // port 0 becomes outputs, so its bit 0 follows the output register, not the pin
  task automatic test_expander_inputs();
    send_event(OP_ADDR, EXP_WR | SUB_BITS, 24'($urandom));
    send_event(OP_WRITE, REG_DIR0, 24'($urandom));
    send_event(OP_WRITE, 8'h00, 24'($urandom));
    send_event(OP_STOP, 8'hff, 24'($urandom));
    send_event(OP_ADDR, EXP_WR | RD_BIT, PINS_LOW);
    send_event(OP_READ, 8'h00, PINS_HIGH);
    send_event(OP_READ, 8'h00, PINS_LOW);
    send_event(OP_STOP, 8'h00, PINS_HIGH);
  endtask

  // last LED slot, one write past the end, then a launch of the largest count
  task automatic test_led_store();
    send_event(OP_ADDR, LED_WR | SUB_BITS, 24'($urandom));
    send_event(OP_WRITE, 8'(LED_CAPACITY - 1), 24'($urandom));
    send_event(OP_WRITE, 8'hff, 24'($urandom));
    send_event(OP_WRITE, 8'h5a, 24'($urandom));
    send_event(OP_WRITE, 8'h00, 24'($urandom));
    send_event(OP_WRITE, 8'h33, 24'($urandom));
    send_event(OP_STOP, 8'h00, 24'($urandom));
    send_event(OP_ADDR, LED_WR, 24'($urandom));
    send_event(OP_WRITE, LED_COUNT_REG, 24'($urandom));
    send_event(OP_WRITE, 8'hff, 24'($urandom));
    send_event(OP_STOP, 8'h00, 24'($urandom));
  endtask

  // nobody answers, then a read straight after a write address
  task automatic test_unmapped_device();
    send_event(OP_ADDR, NO_DEV_WR, 24'($urandom));
    send_event(OP_WRITE, 8'h12, 24'($urandom));
    send_event(OP_READ, 8'h00, 24'($urandom));
    send_event(OP_ADDR, LED_WR, 24'($urandom));
    send_event(OP_READ, 8'h00, 24'($urandom));
    send_event(OP_STOP, 8'h00, 24'($urandom));
  endtask

  task automatic run_random_transaction();
    logic [7:0]  addr;
    logic [7:0]  ptr;
    int unsigned roll;
    bit          to_leds;
    if ($urandom_range(99) < 8) begin
      send_event(op_t'($urandom_range(3)), 8'($urandom), 24'($urandom));
      return;
    end
    to_leds = 1'($urandom_range(1));
    addr = (to_leds ? LED_WR : EXP_WR) | (8'($urandom) & SUB_BITS);
    if ($urandom_range(19) == 0) addr = 8'($urandom) & ~RD_BIT;
    roll = $urandom_range(9);
    if (to_leds) begin
      if (roll < 3) ptr = LED_COUNT_REG;
      else if (roll < 8) ptr = 8'($urandom_range(15));
      else if (roll < 9) ptr = 8'($urandom_range(LED_CAPACITY - 1));
      else ptr = 8'($urandom);
    end else if (roll < 8) begin
      roll = roll % 6;
      ptr = (roll < 2 ? REG_INPUT0 : roll < 4 ? REG_OUTPUT0 : REG_DIR0) + 8'(roll % 2);
    end else begin
      ptr = 8'($urandom);
    end
    send_event(OP_ADDR, addr, 24'($urandom));
    if ($urandom_range(19) != 0) send_event(OP_WRITE, ptr, 24'($urandom));
    if ($urandom_range(1)) begin
      repeat ($urandom_range(1, 4)) send_event(OP_WRITE, pick_byte(), 24'($urandom));
    end else begin
      send_event(OP_ADDR, addr | RD_BIT, 24'($urandom));
      repeat ($urandom_range(1, 4)) send_event(OP_READ, 8'($urandom), 24'($urandom));
    end
    if ($urandom_range(9) != 0) send_event(OP_STOP, 8'($urandom), 24'($urandom));
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    first = events_sent;
    while (events_sent - first < RANDOM_EVENTS) begin
      steady = (events_sent - first) >= 600 && (events_sent - first) < 900;
      run_random_transaction();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_expander_outputs();
    wait_for_replies();
    test_expander_inputs();
    test_led_store();
    test_unmapped_device();
    wait_for_replies();
    test_random_traffic();
    wait_for_replies();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[i2c_gpio_expander_led_regs] OK");
    end else begin
      $display("[i2c_gpio_expander_led_regs] ERROR");
    end
    $finish;
  end

endmodule
